>>> rtl/rfoc_pkg.sv
package rfoc_pkg;

  localparam int MAX_SIDE_DEF      = 512;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int SYM_W   = 8;
  localparam int FIELD_W = 19;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 8;
  localparam int ROW_W   = 9;

  // stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int S_DATA_W = 112;
  localparam int M_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_DRAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FILLED  = 8'h52;  // 'R'
  localparam logic [KIND_W-1:0] KIND_OUTLINE = 8'h72;  // 'r'

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int SIZE_W     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd1;
  localparam logic [SYM_W-1:0]  BG_RESET   = 8'd32;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

endpackage

>>> rtl/rfoc_mem.sv
module rfoc_mem import rfoc_pkg::*; #(
  parameter int ADDR_W = 18
) (
  input  logic              clk_i,
  input  mem_cmd_t          cmd_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [SYM_W-1:0]  wdata_i,
  output logic [SYM_W-1:0]  rdata_o
);

  logic [SYM_W-1:0] cells_q [(1 << ADDR_W)];
  logic [SYM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      cells_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= cells_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rfoc_ctrl.sv
module rfoc_ctrl import rfoc_pkg::*; #(
  parameter int MAX_SIDE      = MAX_SIDE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
  localparam int CNT_W  = $clog2(MAX_SIDE + 1),
  localparam int ADDR_W = 2 * SIDE_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic [MODE_W-1:0]   s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic [CNT_W-1:0]    w_use_i,
  input  logic [CNT_W-1:0]    h_use_i,
  input  logic [SYM_W-1:0]    bg_i,
  output mem_cmd_t            mem_cmd_o,
  output logic [ADDR_W-1:0]   mem_addr_o,
  output logic [SYM_W-1:0]    mem_wdata_o,
  input  logic [SYM_W-1:0]    mem_rdata_i
);

  localparam int XW    = (SIDE_W + FRACTION_BITS > FIELD_W) ? SIDE_W + FRACTION_BITS : FIELD_W;
  localparam int CW    = XW + 2;
  localparam int CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;
  localparam logic signed [CW-1:0] OneFx = CW'(1) << FRACTION_BITS;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_RD_ADDR = 3'd2;
  localparam logic [2:0] ST_RD_DATA = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;

  logic [2:0] state_q;

  // input word fields
  logic signed [FIELD_W-1:0] in_left, in_top, in_span_x, in_span_y;
  logic [KIND_W-1:0] in_kind;
  logic [SYM_W-1:0]  in_sym;
  logic [ROW_W-1:0]  in_row, in_col;

  assign in_left   = s_axis_tdata[18:0];
  assign in_top    = s_axis_tdata[37:19];
  assign in_span_x = s_axis_tdata[56:38];
  assign in_span_y = s_axis_tdata[75:57];
  assign in_kind   = s_axis_tdata[83:76];
  assign in_sym    = s_axis_tdata[91:84];
  assign in_row    = s_axis_tdata[100:92];
  assign in_col    = s_axis_tdata[109:101];

  logic draw_ok, canvas_empty, read_hit, accept;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign draw_ok = !in_span_x[FIELD_W-1] && (in_span_x != '0) &&
                   !in_span_y[FIELD_W-1] && (in_span_y != '0) &&
                   ((in_kind == KIND_FILLED) || (in_kind == KIND_OUTLINE));
  assign canvas_empty = (w_use_i == '0) || (h_use_i == '0);
  assign read_hit = (CMP_W'(in_row) < CMP_W'(h_use_i)) && (CMP_W'(in_col) < CMP_W'(w_use_i));

  // scan position and running edge distances (fixed point)
  logic [CNT_W-1:0] c_q, r_q;
  logic signed [CW-1:0] dx_q, ex_q, dy_q, ey_q, negl_q, redge_q;
  logic filled_q, force_q;
  logic [SYM_W-1:0] sym_q;

  logic in_x, in_y, bd_x, bd_y, paint;
  logic col_last, row_last;

  assign in_x  = !dx_q[CW-1] && !ex_q[CW-1];
  assign in_y  = !dy_q[CW-1] && !ey_q[CW-1];
  assign bd_x  = (dx_q < OneFx) || (ex_q < OneFx);
  assign bd_y  = (dy_q < OneFx) || (ey_q < OneFx);
  assign paint = force_q || (in_x && in_y && (filled_q || bd_x || bd_y));

  assign col_last = (c_q + CNT_W'(1)) == w_use_i;
  assign row_last = (r_q + CNT_W'(1)) == h_use_i;

  assign mem_cmd_o.wr = (state_q == ST_SCAN) && paint;
  assign mem_cmd_o.rd = (state_q == ST_RD_ADDR);
  assign mem_addr_o   = {r_q[SIDE_W-1:0], c_q[SIDE_W-1:0]};
  assign mem_wdata_o  = sym_q;

  logic res_status_q;
  logic [SYM_W-1:0] res_sym_q;
  logic m_valid_q, m_status_q;
  logic [SYM_W-1:0] m_sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      // finish handles the output register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (s_axis_tuser)
              MODE_DRAW: begin
                if (draw_ok && !canvas_empty) begin
                  state_q <= ST_SCAN;
                end else begin
                  state_q <= ST_FINISH;
                end
              end
              MODE_CLEAR: begin
                state_q <= canvas_empty ? ST_FINISH : ST_SCAN;
              end
              MODE_READ: begin
                state_q <= read_hit ? ST_RD_ADDR : ST_FINISH;
              end
              default: begin
                state_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (col_last && row_last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_RD_ADDR: begin
          state_q <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_status_q <= (s_axis_tuser == MODE_DRAW) && !draw_ok;
          res_sym_q    <= '0;
          filled_q     <= (in_kind == KIND_FILLED);
          force_q      <= (s_axis_tuser == MODE_CLEAR);
          sym_q        <= (s_axis_tuser == MODE_CLEAR) ? bg_i : in_sym;
          negl_q       <= -CW'(in_left);
          redge_q      <= CW'(in_left) + CW'(in_span_x);
          dx_q         <= -CW'(in_left);
          ex_q         <= CW'(in_left) + CW'(in_span_x);
          dy_q         <= -CW'(in_top);
          ey_q         <= CW'(in_top) + CW'(in_span_y);
          if (s_axis_tuser == MODE_READ) begin
            r_q <= CNT_W'(in_row);
            c_q <= CNT_W'(in_col);
          end else begin
            r_q <= '0;
            c_q <= '0;
          end
        end
      end
      ST_SCAN: begin
        if (col_last) begin
          c_q  <= '0;
          r_q  <= r_q + CNT_W'(1);
          dx_q <= negl_q;
          ex_q <= redge_q;
          dy_q <= dy_q + OneFx;
          ey_q <= ey_q - OneFx;
        end else begin
          c_q  <= c_q + CNT_W'(1);
          dx_q <= dx_q + OneFx;
          ex_q <= ex_q - OneFx;
        end
      end
      ST_RD_DATA: begin
        res_sym_q <= mem_rdata_i;
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_status_q <= res_status_q;
          m_sym_q    <= res_sym_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(M_DATA_W - SYM_W - 1){1'b0}}, m_sym_q, m_status_q};

`ifndef ASSERT_OFF
  a_scan_in_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((c_q < w_use_i) && (r_q < h_use_i)))
    else $error("scan position outside canvas in use");

  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_DATA) |-> $past(mem_cmd_o.rd))
    else $error("read data taken without a read one cycle earlier");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result word appeared outside finish");

  a_clear_writes_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && force_q) |-> mem_cmd_o.wr)
    else $error("clear skipped a cell");
`endif

endmodule

>>> rtl/rectangle_fill_outline_canvas.sv
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tdata: rect_left, rect_top, rect_span_x, rect_span_y, rect_kind,
//                paint_symbol, cell_row, cell_column; tuser: mode
// m_axis    out  tdata: status, cell_symbol
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, one register per write
//
// Draw and clear scan every cell of the size in use, one canvas cell per cycle
// through the single memory write port; a read inside the canvas adds a read-address
// and a read-data step; reads outside, no-op, rejects and an empty canvas finish.
// One word in flight; the next word is accepted while the result waits in the
// output register. A full output register stalls only the finish step.
// Reset restores the config registers; canvas contents are undefined until written.
module rectangle_fill_outline_canvas import rfoc_pkg::*; #(
  parameter int MAX_SIDE      = MAX_SIDE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // rect_left[18:0], rect_top[37:19], rect_span_x[56:38], rect_span_y[75:57],
  // rect_kind[83:76], paint_symbol[91:84], cell_row[100:92], cell_column[109:101]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[0], cell_symbol[8:1]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CNT_W  = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W = 2 * SIDE_W;
  localparam int SZ_CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [SIZE_W-1:0] width_q, height_q;
  logic [SYM_W-1:0]  bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
      bg_q     <= BG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_CANVAS_HEIGHT: height_q <= cfg_data_i[SIZE_W-1:0];
        CFG_BACKGROUND:    bg_q     <= cfg_data_i[SYM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sizes above MAX_SIDE act as MAX_SIDE
  logic [CNT_W-1:0] w_use, h_use;

  assign w_use = (SZ_CMP_W'(width_q) > SZ_CMP_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE)
                                                            : CNT_W'(width_q);
  assign h_use = (SZ_CMP_W'(height_q) > SZ_CMP_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE)
                                                             : CNT_W'(height_q);

  mem_cmd_t          mem_cmd;
  logic [ADDR_W-1:0] mem_addr;
  logic [SYM_W-1:0]  mem_wdata, mem_rdata;

  rfoc_ctrl #(
    .MAX_SIDE      (MAX_SIDE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .w_use_i       (w_use),
    .h_use_i       (h_use),
    .bg_i          (bg_q),
    .mem_cmd_o     (mem_cmd),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  rfoc_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
